// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/idfa_pkg.sv =====
`default_nettype none

package idfa_pkg;

   localparam int DEF_MAX_IDS    = 1024;
   localparam int DEF_ID_BITS    = 32;
   localparam int CFG_BITS       = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CFG_BITS-1:0] RESET_LOWEST  = 32'd0;
   localparam logic [CFG_BITS-1:0] RESET_HIGHEST = 32'd1023;

   localparam logic [CSR_INDEX_BITS-1:0] REG_LOWEST  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HIGHEST = 2'd1;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_IGNORED   = 2'd2
   } status_type;

   // control from the top level to the stack core
   typedef struct packed {
      logic accept;
      logic rebuild;
   } ctl_type;

endpackage

`default_nettype wire

// ===== hdl/idfa_ram.sv =====
`default_nettype none

module idfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/idfa_core.sv =====
`default_nettype none

module idfa_core #(
   parameter int MAX_IDS = idfa_pkg::DEF_MAX_IDS,
   parameter int ID_BITS = idfa_pkg::DEF_ID_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire idfa_pkg::ctl_type                   ctl,
   input  wire logic                                req_operation,
   input  wire logic [ID_BITS-1:0]                  req_release_id,
   input  wire logic [idfa_pkg::CFG_BITS-1:0]       lowest_id,
   input  wire logic [idfa_pkg::CFG_BITS-1:0]       highest_id,
   input  wire logic [$clog2(MAX_IDS+1)-1:0]        range_size,
   output logic      [ID_BITS-1:0]                  granted_id,
   output idfa_pkg::status_type                     status
);

   import idfa_pkg::*;

   localparam int AW = $clog2(MAX_IDS);
   localparam int CW = $clog2(MAX_IDS+1);

   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       peak_ff, peak_in;
   logic                fwd_valid_ff, fwd_valid_in;
   logic [ID_BITS-1:0]  fwd_id_ff, fwd_id_in;
   logic                wr_en;
   logic [ID_BITS-1:0]  rd_data;
   logic [CFG_BITS-1:0] seed_sum;
   logic [ID_BITS-1:0]  top_entry;
   logic                alloc_ok;
   logic                rel_ok;

   idfa_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (MAX_IDS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_in[AW-1:0]),
      .wr_data (req_release_id),
      .rd_addr (count_in[AW-1:0]),
      .rd_data (rd_data)
   );

   // entries at or above the peak were never written: they hold lowest plus index
   assign seed_sum = lowest_id + CFG_BITS'(count_ff);

   always_comb begin
      if (fwd_valid_ff) begin
         top_entry = fwd_id_ff;
      end else if (count_ff < peak_ff) begin
         top_entry = rd_data;
      end else begin
         top_entry = seed_sum[ID_BITS-1:0];
      end
   end

   assign alloc_ok = (count_ff < range_size);
   assign rel_ok   = (req_release_id != {ID_BITS{1'b1}}) &&
                     (CFG_BITS'(req_release_id) <= highest_id) &&
                     (count_ff != '0);

   always_comb begin
      granted_id = {ID_BITS{1'b1}};
      status     = STATUS_DONE;
      if (req_operation == OP_ALLOC) begin
         if (alloc_ok) begin
            granted_id = top_entry;
         end else begin
            status = STATUS_EXHAUSTED;
         end
      end else if (!rel_ok) begin
         status = STATUS_IGNORED;
      end
   end

   always_comb begin
      count_in     = count_ff;
      peak_in      = peak_ff;
      fwd_valid_in = 1'b0;
      fwd_id_in    = fwd_id_ff;
      wr_en        = 1'b0;
      if (ctl.rebuild) begin
         count_in = '0;
         peak_in  = '0;
      end else if (ctl.accept) begin
         if (req_operation == OP_ALLOC) begin
            if (alloc_ok) begin
               count_in = CW'(count_ff + 1'b1);
               if (count_ff == peak_ff) begin
                  peak_in = CW'(peak_ff + 1'b1);
               end
            end
         end else if (rel_ok) begin
            // push lands on the new top, forward it past the read latency
            count_in     = CW'(count_ff - 1'b1);
            wr_en        = 1'b1;
            fwd_valid_in = 1'b1;
            fwd_id_in    = req_release_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         peak_ff      <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_id_ff <= fwd_id_in;
   end

endmodule

`default_nettype wire

// ===== hdl/id_free_list_allocator.sv =====
// id free-list allocator: stack of free ids in one ram with registered read
// result: registered, presented in the cycle after the request transfer
// throughput: one request per cycle while results are taken; top-of-stack ram read
//    prefetched from the next pointer, a push forwarded for the following request
// reset or a bound register write: range set, pointer and peak mark cleared;
//    no clearing pass, entries above the peak mark read as lowest_id plus index
`default_nettype none

module id_free_list_allocator #(
   parameter int MAX_IDS = idfa_pkg::DEF_MAX_IDS,
   parameter int ID_BITS = idfa_pkg::DEF_ID_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_operation,
   input  wire logic [ID_BITS-1:0]                  req_release_id,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [ID_BITS-1:0]                  rsp_granted_id,
   output logic      [1:0]                          rsp_status,
   // register write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [idfa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [idfa_pkg::CFG_BITS-1:0]       csr_data
);

   import idfa_pkg::*;

   localparam int CW = $clog2(MAX_IDS+1);
   localparam int unsigned RESET_SPAN  = int'(RESET_HIGHEST) - int'(RESET_LOWEST) + 1;
   localparam int unsigned RESET_RANGE = (RESET_SPAN > MAX_IDS) ? MAX_IDS : RESET_SPAN;

   logic [CFG_BITS-1:0] lowest_ff, lowest_in;
   logic [CFG_BITS-1:0] highest_ff, highest_in;
   logic [CW-1:0]       range_ff, range_in;
   logic [CFG_BITS:0]   span;
   logic                csr_fire;
   logic                rebuild;
   ctl_type             ctl;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]  granted_ff;
   logic [1:0]          status_ff;
   logic [ID_BITS-1:0]  core_granted;
   status_type          core_status;
   logic                req_fire;

   // the user must issue register writes only while the block is idle; it does not enforce this
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      rebuild    = 1'b0;
      case (csr_index)
         REG_LOWEST: begin
            lowest_in = csr_data;
            rebuild   = csr_fire;
         end
         REG_HIGHEST: begin
            highest_in = csr_data;
            rebuild    = csr_fire;
         end
         default: begin
            rebuild = 1'b0;
         end
      endcase
   end

   // range size from the new register values: empty when inverted, capped at depth
   assign span = {1'b0, highest_in} - {1'b0, lowest_in} + 1'b1;

   always_comb begin
      range_in = range_ff;
      if (rebuild) begin
         if (highest_in < lowest_in) begin
            range_in = '0;
         end else if (span > (CFG_BITS+1)'(MAX_IDS)) begin
            range_in = CW'(MAX_IDS);
         end else begin
            range_in = span[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff  <= RESET_LOWEST;
         highest_ff <= RESET_HIGHEST;
         range_ff   <= CW'(RESET_RANGE);
      end else if (csr_fire) begin
         lowest_ff  <= lowest_in;
         highest_ff <= highest_in;
         range_ff   <= range_in;
      end
   end

   // output register: a new request is taken when the slot is empty or frees this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign ctl.accept  = req_fire;
   assign ctl.rebuild = rebuild;

   idfa_core #(
      .MAX_IDS (MAX_IDS),
      .ID_BITS (ID_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_operation  (req_operation),
      .req_release_id (req_release_id),
      .lowest_id      (lowest_ff),
      .highest_id     (highest_ff),
      .range_size     (range_ff),
      .granted_id     (core_granted),
      .status         (core_status)
   );

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload captured on every request transfer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         granted_ff <= core_granted;
         status_ff  <= core_status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = granted_ff;
   assign rsp_status     = status_ff;

endmodule

`default_nettype wire

// ===== hdl/idfa_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module idfa_checker #(
   parameter int ID_BITS = idfa_pkg::DEF_ID_BITS
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                req_operation,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [ID_BITS-1:0]                  rsp_granted_id,
   input wire logic [1:0]                          rsp_status
);

   import idfa_pkg::*;

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_granted_id) && $stable(rsp_status))

   // every request transfer yields a result in the next cycle
   `ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid)

   // a real id is only handed out with a done status
   `ASSERT_IMPLY(a_grant_done, clock, reset,
      rsp_valid && (rsp_granted_id != {ID_BITS{1'b1}}), rsp_status == STATUS_DONE)

   // a release never reports exhausted and never grants an id
   `ASSERT_NEXT(a_release_result, clock, reset,
      req_valid && req_ready && (req_operation == OP_RELEASE),
      (rsp_status != STATUS_EXHAUSTED) && (rsp_granted_id == {ID_BITS{1'b1}}))

endmodule

bind id_free_list_allocator idfa_checker #(
   .ID_BITS (ID_BITS)
) u_idfa_checker (.*);

`default_nettype wire
